>>> hdl/dbclp_pkg.sv
// ----------------------------------------------------------------------------
// dbclp_pkg
// Shared types and constants of the two-button click / long-press block.
// ----------------------------------------------------------------------------
package dbclp_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int QD_AW       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = QD_AW + 1;

  localparam int TS_W  = 32;
  localparam int CFG_W = 16;
  localparam int CFG_IW = 1;

  localparam logic [CFG_IW-1:0] CFG_DEBOUNCE   = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_LONG_PRESS = 1'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd600;

  localparam logic [CNT_W-1:0] QD_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [QD_AW-1:0] QD_LAST = QD_AW'(QUEUE_DEPTH - 1);

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_LONG  = 2'd2
  } ev_kind_t;

  // per-lane findings handed to the merge stage
  typedef struct packed {
    logic ev_valid;
    logic ev_long;
    logic held;
  } lane_out_t;

  // queue entry: long flag and button
  typedef struct packed {
    logic is_long;
    logic button;
  } ev_code_t;

  typedef struct packed {
    logic     event_button;
    ev_kind_t event_kind;
    logic     held_a;
    logic     held_b;
  } res_t;

endpackage

>>> hdl/dbclp_if.sv
// ----------------------------------------------------------------------------
// dbclp_in_if / dbclp_out_if
// Valid/ready channels for samples and results.
// ----------------------------------------------------------------------------
interface dbclp_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] now_ms;
  logic        raw_a;
  logic        raw_b;

  modport source (output valid, cmd, now_ms, raw_a, raw_b, input ready);
  modport sink   (input valid, cmd, now_ms, raw_a, raw_b, output ready);
endinterface

interface dbclp_out_if;
  logic       valid;
  logic       ready;
  logic       event_button;
  logic [1:0] event_kind;
  logic       held_a;
  logic       held_b;

  modport source (output valid, event_button, event_kind, held_a, held_b, input ready);
  modport sink   (input valid, event_button, event_kind, held_a, held_b, output ready);
endinterface

>>> hdl/dbclp_lane.sv
// ----------------------------------------------------------------------------
// dbclp_lane
// Debouncer and click / long-press detector for one button.
// ----------------------------------------------------------------------------
module dbclp_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic                        raw,
  input  logic [dbclp_pkg::TS_W-1:0]  now_ms,
  input  logic [dbclp_pkg::CFG_W-1:0] debounce_ms,
  input  logic [dbclp_pkg::CFG_W-1:0] long_press_ms,
  output dbclp_pkg::lane_out_t        lane_out
);
  import dbclp_pkg::*;

  logic            stable_r, stable_nxt;
  logic            last_raw_r;
  logic [TS_W-1:0] last_change_r, last_change_nxt;
  logic [TS_W-1:0] press_start_r, press_start_nxt;
  logic            long_r, long_nxt;

  logic            chg;
  logic [TS_W-1:0] deb_diff;
  logic [TS_W-1:0] press_diff;
  logic            settle;
  logic            press_acc;
  logic            long_eff;
  logic            click;
  logic            long_hit;

  always_comb begin
    chg             = raw != last_raw_r;
    last_change_nxt = chg ? now_ms : last_change_r;
    deb_diff        = chg ? '0 : (now_ms - last_change_r);
    settle          = (raw != stable_r) && (deb_diff >= {{(TS_W-CFG_W){1'b0}}, debounce_ms});
    stable_nxt      = settle ? raw : stable_r;
    press_acc       = settle && raw;
    press_start_nxt = press_acc ? now_ms : press_start_r;
    long_eff        = press_acc ? 1'b0 : long_r;
    press_diff      = press_acc ? '0 : (now_ms - press_start_r);
    click           = settle && !raw && !long_r;
    long_hit        = !click && stable_nxt && !long_eff &&
                      (press_diff >= {{(TS_W-CFG_W){1'b0}}, long_press_ms});
    long_nxt        = long_hit | long_eff;

    lane_out.ev_valid = click | long_hit;
    lane_out.ev_long  = long_hit;
    lane_out.held     = stable_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r      <= 1'b0;
      last_raw_r    <= 1'b0;
      last_change_r <= '0;
      press_start_r <= '0;
      long_r        <= 1'b0;
    end else if (fire) begin
      stable_r      <= stable_nxt;
      last_raw_r    <= raw;
      last_change_r <= last_change_nxt;
      press_start_r <= press_start_nxt;
      long_r        <= long_nxt;
    end
  end

`ifndef SYNTH
  // a long press is only ever reported while the button is held
  a_long_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
    lane_out.ev_long |-> lane_out.held)
    else $error("long press without held level");
  // a click comes only from a release
  a_click_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_out.ev_valid && !lane_out.ev_long) |-> (stable_r && !lane_out.held))
    else $error("click without release");
`endif

endmodule

>>> hdl/dbclp_queue.sv
// ----------------------------------------------------------------------------
// dbclp_queue
// Merges the lane events into the event queue, A before B, and pops one.
// ----------------------------------------------------------------------------
module dbclp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic                 pop_req,
  input  dbclp_pkg::lane_out_t lane_a,
  input  dbclp_pkg::lane_out_t lane_b,
  output logic                 event_button,
  output dbclp_pkg::ev_kind_t  event_kind
);
  import dbclp_pkg::*;

  ev_code_t         mem_r   [QUEUE_DEPTH];
  ev_code_t         mem_nxt [QUEUE_DEPTH];
  logic [QD_AW-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [CNT_W-1:0] cnt1, cnt2;
  logic [CNT_W-1:0] sum_a, sum_b;
  logic [QD_AW-1:0] tail_a, tail_b;
  logic             push_a, push_b, pop;
  ev_code_t         head_code;

  always_comb begin
    mem_nxt = mem_r;
    push_a  = lane_a.ev_valid && (cnt_r < QD_FULL);
    sum_a   = {1'b0, head_r} + cnt_r;
    tail_a  = (sum_a >= QD_FULL) ? QD_AW'(sum_a - QD_FULL) : sum_a[QD_AW-1:0];
    if (push_a) begin
      mem_nxt[tail_a] = '{is_long: lane_a.ev_long, button: 1'b0};
    end
    cnt1    = cnt_r + CNT_W'(push_a);
    push_b  = lane_b.ev_valid && (cnt1 < QD_FULL);
    sum_b   = {1'b0, head_r} + cnt1;
    tail_b  = (sum_b >= QD_FULL) ? QD_AW'(sum_b - QD_FULL) : sum_b[QD_AW-1:0];
    if (push_b) begin
      mem_nxt[tail_b] = '{is_long: lane_b.ev_long, button: 1'b1};
    end
    cnt2      = cnt1 + CNT_W'(push_b);
    pop       = pop_req && (cnt2 != '0);
    head_code = mem_nxt[head_r];
    head_nxt  = pop ? ((head_r == QD_LAST) ? '0 : head_r + 1'b1) : head_r;
    cnt_nxt   = cnt2 - CNT_W'(pop);

    event_button = pop ? head_code.button : 1'b0;
    if (!pop) begin
      event_kind = EV_NONE;
    end else if (head_code.is_long) begin
      event_kind = EV_LONG;
    end else begin
      event_kind = EV_CLICK;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      mem_r <= mem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else if (fire) begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QD_FULL)
    else $error("queue count beyond depth");
  a_empty_none: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 && !lane_a.ev_valid && !lane_b.ev_valid) |-> (event_kind == EV_NONE))
    else $error("event popped from empty queue");
`endif

endmodule

>>> hdl/dual_button_click_longpress.sv
// ----------------------------------------------------------------------------
// dual_button_click_longpress
// Two debounced buttons with click and long-press events and an event queue.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one sample per item: timestamp in ms, raw levels of buttons
//   A and B, and cmd (1 = pop one queued event after the sample is applied).
//   out_ch returns exactly one result per item: the popped event (button and
//   kind, none when nothing is queued or no pop was asked) and both debounced
//   levels after the sample.
//   cfg_we/cfg_index/cfg_wdata write debounce_ms (index 0) and long_press_ms
//   (index 1); write only while no item is in flight.
// Timing:
//   one item per cycle while in_ch.ready is high; results are registered in
//   out_r or skid_r. Both lanes and the queue update in the accepting cycle.
// Stall:
//   a two-entry output stage (output register plus skid register) lets one
//   more item enter while a result waits; in_ch.ready drops while the skid
//   register is full.
// Reset:
//   rst_n is synchronous; both buttons released, queue empty, registers at
//   20 ms debounce and 600 ms long press.
// ----------------------------------------------------------------------------
module dual_button_click_longpress (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [dbclp_pkg::CFG_IW-1:0] cfg_index,
  input  logic [dbclp_pkg::CFG_W-1:0]  cfg_wdata,
  dbclp_in_if.sink                     in_ch,
  dbclp_out_if.source                  out_ch
);
  import dbclp_pkg::*;

  logic [CFG_W-1:0] debounce_r;
  logic [CFG_W-1:0] long_press_r;

  logic      in_fire;
  logic      out_take;
  lane_out_t lane_a, lane_b;
  logic      q_button;
  ev_kind_t  q_kind;
  res_t      res;

  res_t      out_r, out_nxt;
  res_t      skid_r, skid_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:   debounce_r   <= cfg_wdata;
        CFG_LONG_PRESS: long_press_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && !skid_valid_r;
  assign out_take    = out_valid_r && out_ch.ready;

  dbclp_lane u_lane_a (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (in_fire),
    .raw          (in_ch.raw_a),
    .now_ms       (in_ch.now_ms),
    .debounce_ms  (debounce_r),
    .long_press_ms(long_press_r),
    .lane_out     (lane_a)
  );

  dbclp_lane u_lane_b (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (in_fire),
    .raw          (in_ch.raw_b),
    .now_ms       (in_ch.now_ms),
    .debounce_ms  (debounce_r),
    .long_press_ms(long_press_r),
    .lane_out     (lane_b)
  );

  dbclp_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (in_fire),
    .pop_req     (in_ch.cmd),
    .lane_a      (lane_a),
    .lane_b      (lane_b),
    .event_button(q_button),
    .event_kind  (q_kind)
  );

  always_comb begin
    res.event_button = q_button;
    res.event_kind   = q_kind;
    res.held_a       = lane_a.held;
    res.held_b       = lane_b.held;
  end

  // output register plus skid register
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (in_fire) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_fire) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_button = out_r.event_button;
  assign out_ch.event_kind   = out_r.event_kind;
  assign out_ch.held_a       = out_r.held_a;
  assign out_ch.held_b       = out_r.held_b;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while output is empty");
  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && out_valid_r && !out_ch.ready) |=> skid_valid_r)
    else $error("item lost during output stall");
`endif

endmodule

>>> tb/dual_button_click_longpress_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_button_click_longpress_checker
// Watches the sample, result and register ports of the two-button block,
// predicts every result from its own copy of the debouncers and event queue,
// and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module dual_button_click_longpress_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [dbclp_pkg::CFG_IW-1:0] cfg_index,
  input  logic [dbclp_pkg::CFG_W-1:0]  cfg_wdata,
  dbclp_in_if                          in_ch,
  dbclp_out_if                         out_ch,
  output int unsigned                  mismatches,
  output int unsigned                  outstanding,
  output int unsigned                  clicks_popped,
  output int unsigned                  longs_popped
);
  import dbclp_pkg::*;

  logic [CFG_W-1:0] debounce_cfg;
  logic [CFG_W-1:0] long_cfg;
  logic [1:0]       level_q;
  logic [1:0]       raw_q;
  logic [1:0]       long_done;
  logic [TS_W-1:0]  change_ts [2];
  logic [TS_W-1:0]  press_ts [2];
  ev_code_t         evq [QUEUE_DEPTH];
  int unsigned      evq_head;
  int unsigned      evq_count;
  res_t             result_q [$];

  function automatic ev_kind_t step_button(int i, logic raw, logic [TS_W-1:0] now);
    logic [TS_W-1:0] since_change;
    logic [TS_W-1:0] since_press;
    if (raw != raw_q[i]) begin
      raw_q[i]     = raw;
      change_ts[i] = now;
    end
    since_change = now - change_ts[i];
    if (raw != level_q[i] && since_change >= TS_W'(debounce_cfg)) begin
      level_q[i] = raw;
      if (raw) begin
        press_ts[i]  = now;
        long_done[i] = 1'b0;
      end else if (!long_done[i]) begin
        return EV_CLICK;
      end
    end
    since_press = now - press_ts[i];
    if (level_q[i] && !long_done[i] && since_press >= TS_W'(long_cfg)) begin
      long_done[i] = 1'b1;
      return EV_LONG;
    end
    return EV_NONE;
  endfunction

  // full queue drops the new event
  function automatic void queue_event(int i, ev_kind_t kind);
    ev_code_t    code;
    int unsigned tail;
    if (kind == EV_NONE || evq_count >= QUEUE_DEPTH) return;
    code.is_long = (kind == EV_LONG);
    code.button  = i[0];
    tail         = (evq_head + evq_count) % QUEUE_DEPTH;
    evq[tail]    = code;
    evq_count++;
  endfunction

  function automatic res_t predict_sample(logic cmd, logic [TS_W-1:0] now, logic a, logic b);
    res_t     r;
    ev_code_t code;
    queue_event(0, step_button(0, a, now));
    queue_event(1, step_button(1, b, now));
    r.event_button = 1'b0;
    r.event_kind   = EV_NONE;
    if (cmd && evq_count > 0) begin
      code           = evq[evq_head];
      evq_head       = (evq_head + 1) % QUEUE_DEPTH;
      evq_count--;
      r.event_button = code.button;
      r.event_kind   = code.is_long ? EV_LONG : EV_CLICK;
    end
    r.held_a = level_q[0];
    r.held_b = level_q[1];
    return r;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result();
    res_t want;
    if (result_q.size() == 0) begin
      $error("result arrived with no sample waiting for it");
      mismatches++;
      return;
    end
    want = result_q.pop_front();
    check_field("event_button", want.event_button, out_ch.event_button);
    check_field("event_kind", want.event_kind, out_ch.event_kind);
    check_field("held_a", want.held_a, out_ch.held_a);
    check_field("held_b", want.held_b, out_ch.held_b);
    if (want.event_kind == EV_CLICK) clicks_popped++;
    if (want.event_kind == EV_LONG) longs_popped++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      debounce_cfg  = DEBOUNCE_RST;
      long_cfg      = LONG_PRESS_RST;
      level_q       = '0;
      raw_q         = '0;
      long_done     = '0;
      change_ts     = '{default: '0};
      press_ts      = '{default: '0};
      evq_head      = 0;
      evq_count     = 0;
      result_q.delete();
      mismatches    = 0;
      clicks_popped = 0;
      longs_popped  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEBOUNCE:   debounce_cfg = cfg_wdata;
          CFG_LONG_PRESS: long_cfg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        result_q.push_back(predict_sample(in_ch.cmd, in_ch.now_ms, in_ch.raw_a, in_ch.raw_b));
      end
      if (out_ch.valid && out_ch.ready) check_result();
    end
    outstanding = result_q.size();
  end

endmodule

>>> tb/dual_button_click_longpress_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_button_click_longpress_tb
// Drives samples of two bouncing buttons into the click / long-press block:
// a directed opening for wrap-around, clicks, long presses, an empty and a
// full event queue, then press episodes with random bounce, hold and pop
// patterns plus random noise under several register settings and idle mixes.
// ----------------------------------------------------------------------------
module dual_button_click_longpress_tb;
  import dbclp_pkg::*;

  localparam int PHASES    = 6;
  localparam int PER_PHASE = 250;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  dbclp_in_if  in_ch ();
  dbclp_out_if out_ch ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned clicks_popped;
  int unsigned longs_popped;

  int unsigned tx_idle_pct    = 19;
  int unsigned rx_idle_pct    = 70;
  int unsigned pop_pct        = 50;
  int unsigned step_unit      = 1;
  int unsigned samples_sent   = 0;
  int unsigned settings_used  = 1;
  logic [31:0] now_ms         = '0;
  logic [CFG_W-1:0] db_cur    = DEBOUNCE_RST;
  logic [CFG_W-1:0] lp_cur    = LONG_PRESS_RST;

  logic [CFG_W-1:0] db_plan [PHASES] = '{16'd20, 16'd0, 16'd65535, 16'd3, 16'd65535, 16'd1};
  logic [CFG_W-1:0] lp_plan [PHASES] = '{16'd600, 16'd0, 16'd65535, 16'd40, 16'd0, 16'd7};

  dual_button_click_longpress dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  dual_button_click_longpress_checker result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .clicks_popped (clicks_popped),
    .longs_popped  (longs_popped)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_sample(logic cmd, logic a, logic b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.cmd    <= cmd;
    in_ch.now_ms <= now_ms;
    in_ch.raw_a  <= a;
    in_ch.raw_b  <= b;
    do @(posedge clk); while (!in_ch.ready);
    samples_sent++;
  endtask

  task automatic sample_at(logic cmd, logic [31:0] t, logic a, logic b);
    now_ms = t;
    send_sample(cmd, a, b);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_settings(logic [CFG_W-1:0] db, logic [CFG_W-1:0] lp);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= db;
    @(posedge clk);
    cfg_index <= CFG_LONG_PRESS;
    cfg_wdata <= lp;
    @(posedge clk);
    cfg_we    <= 1'b0;
    db_cur    = db;
    lp_cur    = lp;
    step_unit = (int'(db) + int'(lp)) / 16 + 1;
    settings_used++;
  endtask

  // keeps both raw levels at lv for at least span ms
  task automatic hold_levels(logic [1:0] lv, int unsigned span);
    int unsigned spent;
    int unsigned stride;
    spent = 0;
    do begin
      send_sample($urandom_range(0, 99) < pop_pct, lv[0], lv[1]);
      stride = $urandom_range(1, step_unit);
      spent  += stride;
      now_ms += stride;
    end while (spent <= span);
  endtask

  task automatic press_episode();
    logic [1:0]  sel;
    int unsigned bounces;
    int unsigned hold;
    sel     = 2'($urandom_range(1, 3));
    bounces = $urandom_range(0, 3);
    pop_pct = ($urandom_range(0, 2) == 0) ? 5 : 50;
    for (int k = 0; k < bounces; k++) begin
      hold_levels(sel, $urandom_range(0, db_cur));
      hold_levels(2'b00, $urandom_range(0, db_cur));
    end
    hold = $urandom_range(0, 1) ? $urandom_range(0, lp_cur)
                                : lp_cur + $urandom_range(0, lp_cur / 4 + 8);
    hold_levels(sel, hold + db_cur + step_unit);
    for (int k = 0; k < bounces; k++) begin
      hold_levels(2'b00, $urandom_range(0, db_cur));
      hold_levels(sel, $urandom_range(0, db_cur));
    end
    hold_levels(2'b00, db_cur + step_unit + 1);
  endtask

  task automatic noise_burst();
    int unsigned n;
    n = $urandom_range(1, 10);
    repeat (n) begin
      if ($urandom_range(0, 15) == 0) now_ms = $urandom();
      else now_ms += $urandom_range(0, 2 * step_unit);
      send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned quota;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_DEBOUNCE;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.cmd    <= 1'b0;
    in_ch.now_ms <= '0;
    in_ch.raw_a  <= 1'b0;
    in_ch.raw_b  <= 1'b0;
    step_unit    = (int'(DEBOUNCE_RST) + int'(LONG_PRESS_RST)) / 16 + 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // default timing: empty pop, wrap, long presses, simultaneous clicks
    sample_at(1'b1, 32'd0, 1'b0, 1'b0);
    sample_at(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1);
    sample_at(1'b0, 32'd0, 1'b1, 1'b1);
    sample_at(1'b0, 32'd19, 1'b1, 1'b1);
    sample_at(1'b1, 32'd619, 1'b1, 1'b1);
    sample_at(1'b1, 32'd620, 1'b0, 1'b0);
    sample_at(1'b1, 32'd640, 1'b0, 1'b0);
    sample_at(1'b0, 32'd700, 1'b1, 1'b1);
    sample_at(1'b0, 32'd720, 1'b1, 1'b1);
    sample_at(1'b0, 32'd730, 1'b0, 1'b0);
    sample_at(1'b1, 32'd750, 1'b0, 1'b0);

    // zero timing: long press on the accepted press, queue overflow
    write_settings('0, '0);
    for (int k = 0; k < 4; k++) begin
      sample_at(1'b0, 32'd1000 + 2 * k, 1'b1, 1'b1);
      if (k < 3) sample_at(1'b0, 32'd1001 + 2 * k, 1'b0, 1'b0);
    end
    for (int k = 0; k < 9; k++) sample_at(1'b1, 32'd1010 + k, 1'b0, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      tx_idle_pct = (p < 2) ? 19 : (p < 4) ? 70 : 0;
      rx_idle_pct = (p < 2) ? 70 : (p < 4) ? 19 : 0;
      write_settings(db_plan[p], lp_plan[p]);
      now_ms = $urandom();
      quota  = samples_sent + PER_PHASE;
      while (samples_sent < quota) begin
        if ($urandom_range(0, 9) < 7) press_episode();
        else noise_burst();
      end
    end

    wait_drained();
    repeat (5) @(posedge clk);
    $display("Covered %0d samples under %0d register settings", samples_sent, settings_used);
    $display("Popped %0d clicks and %0d long presses", clicks_popped, longs_popped);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/dbclp_pkg.sv
hdl/dbclp_if.sv
hdl/dbclp_lane.sv
hdl/dbclp_queue.sv
hdl/dual_button_click_longpress.sv
tb/dual_button_click_longpress_checker.sv
tb/dual_button_click_longpress_tb.sv
